// ===== rtl/uft_pkg.sv =====
// uft_pkg: shared types and constants for the union-find cluster tracker.
// Used by uft_walker, uft_merge, union_find_cluster_tracker and uft_checker.
// No dependencies.
package uft_pkg;

	localparam int NODES_DEF      = 1024;
	localparam int NODE_W         = 10;
	localparam int SIZE_W         = 11;
	localparam int SUM_W          = 21;
	localparam int SUM_MAX        = 2097151;
	localparam int SIZE_FIELD_MAX = 2047;

	typedef enum logic [2:0] {
		T_IDLE,
		T_WALK_A,
		T_START_B,
		T_WALK_B,
		T_MERGE,
		T_DONE
	} top_state_t;

	typedef enum logic [1:0] {
		W_CLEAR,
		W_IDLE,
		W_FIND,
		W_COMP
	} walk_state_t;

	typedef enum logic [2:0] {
		M_CLEAR,
		M_IDLE,
		M_RD_A,
		M_RD_B,
		M_MUL,
		M_UPD
	} merge_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

// ===== rtl/union_find_cluster_tracker.sv =====
// Per edge: walk node_a's root chain, then node_b's, then merge the two clusters
// unless both nodes already share a root; an out-of-range edge goes straight to
// the result. One edge at a time, and a stalled result holds. The walker visits
// each link twice, once in the root search and once in the path compression.
// Reset: a clearing pass rewrites both tables; no edge is taken while it runs.
module union_find_cluster_tracker #(
	parameter int NODES = uft_pkg::NODES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  logic [uft_pkg::NODE_W-1:0]  node_a,
	input  logic [uft_pkg::NODE_W-1:0]  node_b,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic                        merged,
	output logic [uft_pkg::SIZE_W-1:0]  peak_size,
	output logic [uft_pkg::NODE_W-1:0]  largest_root,
	output logic [uft_pkg::SUM_W-1:0]   sum_of_squares,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [uft_pkg::SIZE_W-1:0]  present_nodes
);

	localparam int IDX_W = (NODES > 2) ? $clog2(NODES) : 1;
	localparam int SZ_W  = $clog2(NODES + 1);

	uft_pkg::top_state_t state_q, state_d;
	uft_pkg::unit_stat_t wstat, mstat;

	logic             accept;
	logic             in_range;
	logic             walk_start;
	logic [IDX_W-1:0] walk_node;
	logic [IDX_W-1:0] wroot;
	logic             merge_start;
	logic             load_result;
	logic             link_we;
	logic [IDX_W-1:0] link_node;
	logic [IDX_W-1:0] link_parent;
	logic [SZ_W-1:0]  best_size;
	logic [IDX_W-1:0] best_root;
	logic [uft_pkg::SUM_W-1:0] sum;

	logic [IDX_W-1:0] b_q;
	logic [IDX_W-1:0] ra_q;
	logic             merged_q;
	logic             result_valid_q;
	logic             res_merged_q;
	logic [uft_pkg::SIZE_W-1:0] res_size_q;
	logic [uft_pkg::NODE_W-1:0] res_root_q;
	logic [uft_pkg::SUM_W-1:0]  res_sum_q;

	assign item_stall = (state_q != uft_pkg::T_IDLE) || wstat.busy || mstat.busy;
	assign accept     = item_valid && !item_stall;
	assign in_range   = (32'(node_a) < NODES) && (32'(node_b) < NODES);
	assign cfg_ready  = 1'b1;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			uft_pkg::T_IDLE: begin
				if (accept) state_d = in_range ? uft_pkg::T_WALK_A : uft_pkg::T_DONE;
			end
			uft_pkg::T_WALK_A: if (wstat.done) state_d = uft_pkg::T_START_B;
			uft_pkg::T_START_B: state_d = uft_pkg::T_WALK_B;
			uft_pkg::T_WALK_B: begin
				if (wstat.done) state_d = (wroot == ra_q) ? uft_pkg::T_DONE : uft_pkg::T_MERGE;
			end
			uft_pkg::T_MERGE: if (mstat.done) state_d = uft_pkg::T_DONE;
			uft_pkg::T_DONE: begin
				if (!result_valid_q || !result_stall) state_d = uft_pkg::T_IDLE;
			end
			default: state_d = uft_pkg::T_IDLE;
		endcase
	end

	always_comb begin
		walk_start  = 1'b0;
		walk_node   = IDX_W'(node_a);
		merge_start = 1'b0;
		load_result = 1'b0;
		unique case (state_q)
			uft_pkg::T_IDLE:    walk_start = accept && in_range;
			uft_pkg::T_START_B: begin
				walk_start = 1'b1;
				walk_node  = b_q;
			end
			uft_pkg::T_WALK_B:  merge_start = wstat.done && (wroot != ra_q);
			uft_pkg::T_DONE:    load_result = !result_valid_q || !result_stall;
			default: ;
		endcase
	end

	uft_walker #(
		.NODES(NODES)
	) u_walker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (walk_start),
		.start_node  (walk_node),
		.link_we     (link_we),
		.link_node   (link_node),
		.link_parent (link_parent),
		.stat        (wstat),
		.root        (wroot)
	);

	uft_merge #(
		.NODES(NODES)
	) u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (merge_start),
		.root_a      (ra_q),
		.root_b      (wroot),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_value   (present_nodes),
		.stat        (mstat),
		.link_we     (link_we),
		.link_node   (link_node),
		.link_parent (link_parent),
		.best_size   (best_size),
		.best_root   (best_root),
		.sum         (sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= uft_pkg::T_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_result) result_valid_q <= 1'b1;
			else if (!result_stall) result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			b_q      <= IDX_W'(node_b);
			merged_q <= 1'b0;
		end
		if (state_q == uft_pkg::T_WALK_A && wstat.done) ra_q <= wroot;
		if (state_q == uft_pkg::T_MERGE && mstat.done) merged_q <= 1'b1;
		if (load_result) begin
			res_merged_q <= merged_q;
			res_size_q   <= (32'(best_size) > uft_pkg::SIZE_FIELD_MAX) ?
				uft_pkg::SIZE_W'(uft_pkg::SIZE_FIELD_MAX) : uft_pkg::SIZE_W'(best_size);
			res_root_q   <= uft_pkg::NODE_W'(best_root);
			res_sum_q    <= sum;
		end
	end

	assign result_valid   = result_valid_q;
	assign merged         = res_merged_q;
	assign peak_size      = res_size_q;
	assign largest_root   = res_root_q;
	assign sum_of_squares = res_sum_q;

endmodule

// ===== rtl/uft_walker.sv =====
// uft_walker: parent table memory with root search and full path compression.
// Also takes the link write of a merge and runs the clearing pass after reset.
// Depends on uft_pkg.
module uft_walker #(
	parameter int NODES = uft_pkg::NODES_DEF,
	localparam int IDX_W = (NODES > 2) ? $clog2(NODES) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [IDX_W-1:0]    start_node,
	input  logic                link_we,
	input  logic [IDX_W-1:0]    link_node,
	input  logic [IDX_W-1:0]    link_parent,
	output uft_pkg::unit_stat_t stat,
	output logic [IDX_W-1:0]    root
);

	uft_pkg::walk_state_t state_q, state_d;

	logic [IDX_W-1:0] parent_mem [NODES];
	logic [IDX_W-1:0] rd_q;
	logic [IDX_W-1:0] raddr;
	logic             we;
	logic [IDX_W-1:0] waddr;
	logic [IDX_W-1:0] wdata;

	logic [IDX_W-1:0] clr_q;
	logic [IDX_W-1:0] cur_q;
	logic [IDX_W-1:0] start_q;
	logic [IDX_W-1:0] top_q;

	logic at_root;
	logic clr_last;
	logic comp_end;

	assign at_root  = (rd_q == cur_q);
	assign clr_last = (clr_q == IDX_W'(NODES - 1));
	assign comp_end = (cur_q == top_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			uft_pkg::W_CLEAR: begin
				if (clr_last) state_d = uft_pkg::W_IDLE;
			end
			uft_pkg::W_IDLE: begin
				if (start) state_d = uft_pkg::W_FIND;
			end
			uft_pkg::W_FIND: begin
				if (at_root) state_d = uft_pkg::W_COMP;
			end
			uft_pkg::W_COMP: begin
				if (comp_end) state_d = uft_pkg::W_IDLE;
			end
			default: state_d = uft_pkg::W_CLEAR;
		endcase
	end

	always_comb begin
		raddr     = cur_q;
		we        = 1'b0;
		waddr     = clr_q;
		wdata     = clr_q;
		stat.busy = (state_q != uft_pkg::W_IDLE);
		stat.done = 1'b0;
		unique case (state_q)
			uft_pkg::W_CLEAR: begin
				we = 1'b1;
			end
			uft_pkg::W_IDLE: begin
				raddr = start_node;
				if (link_we) begin
					we    = 1'b1;
					waddr = link_node;
					wdata = link_parent;
				end
			end
			uft_pkg::W_FIND: begin
				raddr = at_root ? start_q : rd_q;
			end
			uft_pkg::W_COMP: begin
				raddr = rd_q;
				if (comp_end) begin
					stat.done = 1'b1;
				end else begin
					we    = 1'b1;
					waddr = cur_q;
					wdata = top_q;
				end
			end
			default: ;
		endcase
	end

	assign root = top_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= uft_pkg::W_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == uft_pkg::W_CLEAR) clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			uft_pkg::W_IDLE: begin
				cur_q   <= start_node;
				start_q <= start_node;
			end
			uft_pkg::W_FIND: begin
				if (at_root) begin
					top_q <= cur_q;
					cur_q <= start_q;
				end else begin
					cur_q <= rd_q;
				end
			end
			uft_pkg::W_COMP: begin
				cur_q <= rd_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) parent_mem[waddr] <= wdata;
		rd_q <= parent_mem[raddr];
	end

endmodule

// ===== rtl/uft_merge.sv =====
// uft_merge: cluster size memory, union by size, sum of squares and best cluster.
// Drives the link write into the parent table of uft_walker.
// Depends on uft_pkg.
module uft_merge #(
	parameter int NODES = uft_pkg::NODES_DEF,
	localparam int IDX_W = (NODES > 2) ? $clog2(NODES) : 1,
	localparam int SZ_W  = $clog2(NODES + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [IDX_W-1:0]          root_a,
	input  logic [IDX_W-1:0]          root_b,
	input  logic                      cfg_we,
	input  logic [uft_pkg::SIZE_W-1:0] cfg_value,
	output uft_pkg::unit_stat_t       stat,
	output logic                      link_we,
	output logic [IDX_W-1:0]          link_node,
	output logic [IDX_W-1:0]          link_parent,
	output logic [SZ_W-1:0]           best_size,
	output logic [IDX_W-1:0]          best_root,
	output logic [uft_pkg::SUM_W-1:0] sum
);

	localparam int PROD_W = 2 * SZ_W;
	localparam int TOT_W  = ((PROD_W + 1 > uft_pkg::SUM_W) ? PROD_W + 1 : uft_pkg::SUM_W) + 1;

	uft_pkg::merge_state_t state_q, state_d;

	logic [SZ_W-1:0]  size_mem [NODES];
	logic [SZ_W-1:0]  rd_q;
	logic [IDX_W-1:0] raddr;
	logic             we;
	logic [IDX_W-1:0] waddr;
	logic [SZ_W-1:0]  wdata;

	logic [IDX_W-1:0] clr_q;
	logic [IDX_W-1:0] ra_q;
	logic [IDX_W-1:0] rb_q;
	logic [SZ_W-1:0]  sa_q;
	logic [IDX_W-1:0] small_q;
	logic [IDX_W-1:0] big_q;
	logic [SZ_W-1:0]  ss_q;
	logic [SZ_W-1:0]  sb_q;
	logic [PROD_W-1:0] prod_q;
	logic [SZ_W-1:0]  nsize_q;

	logic [SZ_W-1:0]            best_size_q;
	logic [IDX_W-1:0]           best_root_q;
	logic [uft_pkg::SUM_W-1:0]  sum_q;

	logic             clr_last;
	logic [TOT_W-1:0] total;
	logic [uft_pkg::SUM_W-1:0] sum_sat;

	assign clr_last = (clr_q == IDX_W'(NODES - 1));
	assign total    = TOT_W'(sum_q) + TOT_W'({prod_q, 1'b0});
	assign sum_sat  = (total > TOT_W'(uft_pkg::SUM_MAX)) ?
		uft_pkg::SUM_W'(uft_pkg::SUM_MAX) : uft_pkg::SUM_W'(total);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			uft_pkg::M_CLEAR: if (clr_last) state_d = uft_pkg::M_IDLE;
			uft_pkg::M_IDLE:  if (start) state_d = uft_pkg::M_RD_A;
			uft_pkg::M_RD_A:  state_d = uft_pkg::M_RD_B;
			uft_pkg::M_RD_B:  state_d = uft_pkg::M_MUL;
			uft_pkg::M_MUL:   state_d = uft_pkg::M_UPD;
			uft_pkg::M_UPD:   state_d = uft_pkg::M_IDLE;
			default:          state_d = uft_pkg::M_CLEAR;
		endcase
	end

	always_comb begin
		raddr       = root_a;
		we          = 1'b0;
		waddr       = clr_q;
		wdata       = SZ_W'(1);
		link_we     = 1'b0;
		stat.busy   = (state_q != uft_pkg::M_IDLE);
		stat.done   = 1'b0;
		unique case (state_q)
			uft_pkg::M_CLEAR: we = 1'b1;
			uft_pkg::M_RD_A:  raddr = rb_q;
			uft_pkg::M_UPD: begin
				we        = 1'b1;
				waddr     = big_q;
				wdata     = nsize_q;
				link_we   = 1'b1;
				stat.done = 1'b1;
			end
			default: ;
		endcase
	end

	assign link_node   = small_q;
	assign link_parent = big_q;
	assign best_size   = best_size_q;
	assign best_root   = best_root_q;
	assign sum         = sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= uft_pkg::M_CLEAR;
			clr_q       <= '0;
			best_size_q <= SZ_W'(1);
			best_root_q <= '0;
			sum_q       <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == uft_pkg::M_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == uft_pkg::M_UPD) begin
				sum_q <= sum_sat;
				if (best_size_q < nsize_q) begin
					best_size_q <= nsize_q;
					best_root_q <= big_q;
				end
			end
			if (cfg_we) sum_q <= uft_pkg::SUM_W'(cfg_value);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			uft_pkg::M_IDLE: begin
				ra_q <= root_a;
				rb_q <= root_b;
			end
			uft_pkg::M_RD_A: sa_q <= rd_q;
			uft_pkg::M_RD_B: begin
				if (sa_q > rd_q) begin
					small_q <= rb_q;
					ss_q    <= rd_q;
					big_q   <= ra_q;
					sb_q    <= sa_q;
				end else begin
					small_q <= ra_q;
					ss_q    <= sa_q;
					big_q   <= rb_q;
					sb_q    <= rd_q;
				end
			end
			uft_pkg::M_MUL: begin
				prod_q  <= PROD_W'(ss_q) * PROD_W'(sb_q);
				nsize_q <= ss_q + sb_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) size_mem[waddr] <= wdata;
		rd_q <= size_mem[raddr];
	end

endmodule

// ===== rtl/uft_checker.sv =====
// uft_checker: port-level checks of the cluster tracker over time.
// Bound to union_find_cluster_tracker; depends on uft_pkg.
module uft_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       item_valid,
	input logic                       item_stall,
	input logic [uft_pkg::NODE_W-1:0] node_a,
	input logic [uft_pkg::NODE_W-1:0] node_b,
	input logic                       result_valid,
	input logic                       result_stall,
	input logic                       merged,
	input logic [uft_pkg::SIZE_W-1:0] peak_size,
	input logic [uft_pkg::NODE_W-1:0] largest_root,
	input logic [uft_pkg::SUM_W-1:0]  sum_of_squares,
	input logic                       cfg_valid,
	input logic                       cfg_ready,
	input logic [uft_pkg::SIZE_W-1:0] present_nodes
);

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(merged) &&
		$stable(peak_size) && $stable(sum_of_squares))
		else $error("stalled result changed");

	// one edge at a time
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("input taken again right after a transfer");

	// a result only follows work on an edge
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_stall))
		else $error("result without an edge in work");

	// a merge always leaves a cluster of at least two
	a_merge_size: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && merged |-> peak_size >= uft_pkg::SIZE_W'(2))
		else $error("merge reported with largest size below two");

endmodule

bind union_find_cluster_tracker uft_checker u_uft_checker (.*);
